// ===== design/deq_pkg.sv =====
// Package for the double-ended queue unit.
// Holds the op and status codes and the input and result word structs.
// No dependencies.
`default_nettype none

package deq_pkg;

  // Operation codes carried in the op field
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_DUMP       = 3'd4;

  // Status codes carried in each result word
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // One input word
  typedef struct packed {
    logic        [2:0]  op;
    logic signed [31:0] value_in;
  } in_t;

  // One result word
  typedef struct packed {
    logic signed [31:0] value_out;
    logic        [1:0]  status;
    logic        [6:0]  entries_held;
    logic               last;
  } out_t;

endpackage

`default_nettype wire

// ===== design/double_ended_queue_unit.sv =====
// Double-ended queue unit: ring store in one synchronous memory plus head and count.
// Depends on deq_pkg for op/status codes and the input and result structs.
// Usage:
//   Input channel: drive in_i and raise start; the word is taken at a rising
//   edge where start is high and busy is low. busy is high while a pop or a
//   dump is still reading the memory.
//   Result channel: each result word sits on res_o for one cycle with
//   res_valid_o high. The receiver cannot stall, so every strobe is taken.
//   Per op:
//     push (either end): result in the cycle after accept; a new word can be
//       taken every cycle.
//     pop (either end): the read data is registered in rd_q, then the result
//       word in res_q; busy is high for one cycle and no word is taken meanwhile.
//     dump: one result per stored entry, one per cycle, read through the
//       single memory read port; busy is high while the walk runs.
//     pop or dump on an empty queue, push on a full queue: one status word
//     in the cycle after accept; busy stays low.
//     op codes 5 to 7 are taken and give no result.
//   Reset: head and count clear at once; the memory holds no reset value and
//   entries are only read after they were written. No clearing pass.
`default_nettype none

module double_ended_queue_unit #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire deq_pkg::in_t  in_i,
  output logic               res_valid_o,
  output deq_pkg::out_t      res_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = PW + 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_q;

  logic [1:0]    state_q, state_d;
  logic [PW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] rp_q, rp_d;
  logic [CW-1:0] dk_q, dk_d;
  logic          res_valid_q, res_valid_d;
  deq_pkg::out_t res_q, res_d;

  logic                  accept;
  logic                  rd_en, wr_en;
  logic [PW-1:0]         rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [SW-1:0]         tail_sum, tail_last;
  logic [PW-1:0]         tail_slot, last_slot, head_inc, head_dec, rp_inc;
  logic                  full, empty;
  logic signed [31:0]    rd_value;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);
  assign full   = (count_q == CW'(DEPTH));
  assign empty  = (count_q == '0);

  // Ring arithmetic: wrap at DEPTH with one compare each
  assign head_inc  = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
  assign head_dec  = (head_q == '0) ? PW'(DEPTH - 1) : head_q - PW'(1);
  assign rp_inc    = (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
  assign tail_sum  = SW'(head_q) + SW'(count_q);
  assign tail_last = tail_sum - SW'(1);
  assign tail_slot = (tail_sum >= SW'(DEPTH)) ? PW'(tail_sum - SW'(DEPTH)) : PW'(tail_sum);
  assign last_slot = (tail_last >= SW'(DEPTH)) ? PW'(tail_last - SW'(DEPTH))
                                               : PW'(tail_last);

  // Sign-extend the stored word from DATA_WIDTH and cut to 32 bits
  assign rd_value = 32'($signed(rd_q));

  // Next state, memory port control and result word
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    rp_d        = rp_q;
    dk_d        = dk_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    rd_en       = 1'b0;
    rd_addr     = head_q;
    wr_en       = 1'b0;
    wr_addr     = tail_slot;
    wr_data     = DATA_WIDTH'($signed(in_i.value_in));

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.value_out    = '0;
          res_d.status       = deq_pkg::ST_OK;
          res_d.entries_held = 7'(count_q);
          res_d.last         = 1'b1;
          unique case (in_i.op) inside
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
              res_valid_d = 1'b1;
              if (full) begin
                res_d.status = deq_pkg::ST_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CW'(1);
                res_d.entries_held = 7'(count_q + CW'(1));
                if (in_i.op == deq_pkg::OP_PUSH_FRONT) begin
                  wr_addr = head_dec;
                  head_d  = head_dec;
                end
              end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
              if (empty) begin
                res_valid_d  = 1'b1;
                res_d.status = deq_pkg::ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                count_d = count_q - CW'(1);
                state_d = S_POP;
                if (in_i.op == deq_pkg::OP_POP_FRONT) begin
                  rd_addr = head_q;
                  head_d  = head_inc;
                end else begin
                  rd_addr = last_slot;
                end
              end
            end
            deq_pkg::OP_DUMP: begin
              if (empty) begin
                res_valid_d  = 1'b1;
                res_d.status = deq_pkg::ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = head_q;
                rp_d    = head_q;
                dk_d    = '0;
                state_d = S_DUMP;
              end
            end
            default: begin
              // unused op codes: drop the word
            end
          endcase
        end
      end
      S_POP: begin
        res_valid_d        = 1'b1;
        res_d.value_out    = rd_value;
        res_d.status       = deq_pkg::ST_OK;
        res_d.entries_held = 7'(count_q);
        res_d.last         = 1'b1;
        state_d            = S_IDLE;
      end
      S_DUMP: begin
        res_valid_d        = 1'b1;
        res_d.value_out    = rd_value;
        res_d.status       = deq_pkg::ST_OK;
        res_d.entries_held = 7'(count_q);
        res_d.last         = (dk_q == count_q - CW'(1));
        if (dk_q == count_q - CW'(1)) begin
          state_d = S_IDLE;
        end else begin
          // advance to the next entry
          rd_en   = 1'b1;
          rd_addr = rp_inc;
          rp_d    = rp_inc;
          dk_d    = dk_q + CW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      rp_q        <= '0;
      dk_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      rp_q        <= rp_d;
      dk_q        <= dk_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result word register
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Memory write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Memory read port, registered data
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Count never exceeds the ring size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above DEPTH");

  // A pop read always turns into a result on the next cycle
  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |=> (res_valid_o && res_o.last))
    else $error("pop read gave no result");

  // Dump walk stays inside the stored entries
  a_dump_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> (dk_q < count_q))
    else $error("dump index past stored entries");

  // A full status is only reported on a full queue
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status == deq_pkg::ST_FULL))
      |-> (res_o.entries_held == 7'(DEPTH)))
    else $error("full status on a queue that is not full");

  // Pop on an empty queue reports empty next cycle without going busy
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && empty && ((in_i.op == deq_pkg::OP_POP_FRONT) ||
                         (in_i.op == deq_pkg::OP_POP_BACK)))
      |=> (res_valid_o && (res_o.status == deq_pkg::ST_EMPTY) && !busy))
    else $error("empty pop not reported");

endmodule

`default_nettype wire

// ===== tb/double_ended_queue_unit_test.sv =====
// Self-checking testbench for the double-ended queue unit.
// Mirrors the ring store in a small class and compares every result word.
// Depends on deq_pkg and double_ended_queue_unit.
`timescale 1ns / 1ps

module double_ended_queue_unit_test;

  localparam int DEPTH = 64;

  // Op codes the block takes but ignores
  localparam logic [2:0] OP_RSVD_5 = 3'd5;
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  // Shadow copy of the deque; queues the result words each command causes
  class deque_mirror;
    logic signed [31:0] slots [DEPTH];
    int                 head;
    int                 count;
    deq_pkg::out_t      replies_due [$];
    int                 errors;

    function new();
      head   = 0;
      count  = 0;
      errors = 0;
    endfunction

    function void add_reply(logic signed [31:0] v, logic [1:0] st, logic fin);
      deq_pkg::out_t r;
      r.value_out    = v;
      r.status       = st;
      r.entries_held = 7'(count);
      r.last         = fin;
      replies_due.push_back(r);
    endfunction

    // Apply one accepted command word to the shadow state
    function void mirror_command(deq_pkg::in_t w);
      int slot;
      int k;
      case (w.op)
        deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
          if (count >= DEPTH) begin
            add_reply('0, deq_pkg::ST_FULL, 1'b1);
          end else begin
            if (w.op == deq_pkg::OP_PUSH_FRONT) begin
              head        = (head + DEPTH - 1) % DEPTH;
              slots[head] = w.value_in;
            end else begin
              slots[(head + count) % DEPTH] = w.value_in;
            end
            count++;
            add_reply('0, deq_pkg::ST_OK, 1'b1);
          end
        end
        deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
          if (count == 0) begin
            add_reply('0, deq_pkg::ST_EMPTY, 1'b1);
          end else begin
            if (w.op == deq_pkg::OP_POP_FRONT) begin
              slot = head;
              head = (head + 1) % DEPTH;
            end else begin
              slot = (head + count - 1) % DEPTH;
            end
            count--;
            add_reply(slots[slot], deq_pkg::ST_OK, 1'b1);
          end
        end
        deq_pkg::OP_DUMP: begin
          if (count == 0) begin
            add_reply('0, deq_pkg::ST_EMPTY, 1'b1);
          end else begin
            for (k = 0; k < count; k++)
              add_reply(slots[(head + k) % DEPTH], deq_pkg::ST_OK, k == count - 1);
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one result word against the oldest expectation
    function void compare_reply(deq_pkg::out_t got);
      deq_pkg::out_t want;
      if (replies_due.size() == 0) begin
        $error("result word with none expected: value_out %0d status %0d",
               got.value_out, got.status);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (got.value_out !== want.value_out) begin
        $error("value_out expected %0d got %0d", want.value_out, got.value_out);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status expected %0d got %0d", want.status, got.status);
        errors++;
      end
      if (got.entries_held !== want.entries_held) begin
        $error("entries_held expected %0d got %0d", want.entries_held,
               got.entries_held);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last expected %0d got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic          clk_i  = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start  = 1'b0;
  logic          busy;
  deq_pkg::in_t  in_i   = '0;
  logic          res_valid_o;
  deq_pkg::out_t res_o;

  deque_mirror deq = new();
  int          idle_pct = 0;

  double_ended_queue_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always #5 clk_i = ~clk_i;

  // Check every strobed result word
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o === 1'b1) deq.compare_reply(res_o);
  end

  // Pick a value, biased toward the extremes
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh80000000;
      1: return 32'sh7FFFFFFF;
      2: return 32'sh00000000;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Build a random command word from weights in percent; the rest is unused ops
  function automatic deq_pkg::in_t rand_command(int push_w, int pop_w, int dump_w);
    deq_pkg::in_t w;
    int           roll;
    roll       = $urandom_range(99);
    w.value_in = pick_value();
    if (roll < push_w)
      w.op = $urandom_range(1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
    else if (roll < push_w + pop_w)
      w.op = $urandom_range(1) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
    else if (roll < push_w + pop_w + dump_w)
      w.op = deq_pkg::OP_DUMP;
    else
      w.op = 3'($urandom_range(OP_RSVD_7, OP_RSVD_5));
    return w;
  endfunction

  // Drive one command word, idling at random first; hold until it is taken
  task automatic send_word(input deq_pkg::in_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      in_i  = '{op: 3'($urandom_range(7)), value_in: $urandom};
      @(negedge clk_i);
    end
    start = 1'b1;
    in_i  = w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    deq.mirror_command(w);
  endtask

  task automatic send_op(input logic [2:0] op, input logic signed [31:0] v);
    send_word('{op: op, value_in: v});
  endtask

  // Drop start and hold off until every expected word has come back
  task automatic wait_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (deq.replies_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int i;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty cases, ignored ops, extremes at both ends, dumps
    idle_pct = 0;
    send_op(deq_pkg::OP_POP_FRONT, 32'sd7);
    send_op(deq_pkg::OP_POP_BACK, -32'sd7);
    send_op(deq_pkg::OP_DUMP, 32'sd0);
    send_op(OP_RSVD_5, 32'sh7FFFFFFF);
    send_op(OP_RSVD_6, 32'sh80000000);
    send_op(OP_RSVD_7, -32'sd1);
    send_op(deq_pkg::OP_PUSH_BACK, 32'sh80000000);
    send_op(deq_pkg::OP_PUSH_BACK, 32'sh7FFFFFFF);
    send_op(deq_pkg::OP_PUSH_FRONT, 32'sd0);
    send_op(deq_pkg::OP_PUSH_FRONT, -32'sd1);
    send_op(deq_pkg::OP_PUSH_BACK, 32'sh5A5A5A5A);
    send_op(deq_pkg::OP_DUMP, 32'sd0);
    send_op(deq_pkg::OP_POP_FRONT, 32'sd0);
    send_op(deq_pkg::OP_POP_BACK, 32'sd0);
    send_op(deq_pkg::OP_POP_FRONT, 32'sd0);
    send_op(deq_pkg::OP_DUMP, 32'sd0);
    send_op(deq_pkg::OP_POP_BACK, 32'sd0);
    send_op(deq_pkg::OP_POP_BACK, 32'sd0);
    send_op(deq_pkg::OP_POP_BACK, 32'sd0);
    send_op(deq_pkg::OP_DUMP, 32'sd0);
    wait_drained();

    // Mixed traffic with a heavy idle sender
    idle_pct = 53;
    for (i = 0; i < 30; i++) send_word(rand_command(50, 30, 12));

    // Fill to the top, then push into a full store and dump it
    idle_pct = 37;
    while (deq.count < DEPTH) begin
      send_op($urandom_range(1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT,
              pick_value());
    end
    send_op(deq_pkg::OP_PUSH_BACK, pick_value());
    send_op(deq_pkg::OP_PUSH_FRONT, pick_value());
    send_op(deq_pkg::OP_DUMP, pick_value());
    send_op(deq_pkg::OP_PUSH_FRONT, pick_value());
    wait_drained();

    // Pop-heavy traffic back to back, then with gaps
    idle_pct = 0;
    for (i = 0; i < 15; i++) send_word(rand_command(25, 60, 10));
    idle_pct = 37;
    for (i = 0; i < 15; i++) send_word(rand_command(35, 45, 15));

    // Wait out the last words, then let the pipeline settle
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (deq.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule
